/* hdl/lrbb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrbb_pkg - shared types and constants for the line receive buffer
// Sizes of the line store, status codes, operation and register indexes.
// ----------------------------------------------------------------------------
package lrbb_pkg;

  localparam int LineSize = 32;
  localparam int AddrW    = $clog2(LineSize);
  localparam int CountW   = $clog2(LineSize + 1);

  localparam logic [7:0] TermReset = 8'd13;
  localparam logic [7:0] BkspReset = 8'd8;

  typedef enum logic [1:0] {
    StEmpty    = 2'd0,
    StReady    = 2'd1,
    StOverflow = 2'd2
  } status_e;

  typedef enum logic {
    OpReceive = 1'b0,
    OpRead    = 1'b1
  } op_e;

  typedef enum logic {
    CfgTerminator = 1'b0,
    CfgBackspace  = 1'b1
  } cfg_idx_e;

endpackage : lrbb_pkg
`default_nettype wire

/* hdl/lrbb_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrbb_in_if / lrbb_out_if - valid/ready channels of the line buffer
// Input beats carry an operation and a received byte; output beats carry
// one line character or a status report.
// ----------------------------------------------------------------------------
interface lrbb_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink   (input valid, operation, rx_byte, output ready);
endinterface : lrbb_in_if

interface lrbb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       last;

  modport source (output valid, status, out_byte, out_valid, last, input ready);
  modport sink   (input valid, status, out_byte, out_valid, last, output ready);
endinterface : lrbb_out_if
`default_nettype wire

/* hdl/line_receive_buffer_with_backspace_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_receive_buffer_with_backspace_unit - line store with backspace edit
// Gathers received bytes into a line memory, closes the line on the
// terminator and reads the finished line back one character per beat.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                              | handshake
//  ---------+-----+--------------------------------------+-------------
//  in_i     | in  | operation, rx_byte                   | valid/ready
//  out_o    | out | status, out_byte, out_valid, last    | valid/ready
//  cfg      | in  | cfg_idx_i, cfg_data_i                | cfg_we_i
//
//  A receive beat makes at most one write into the line memory and one
//  result. A read beat of a non-empty line holds off the input until its
//  last beat is issued: the line memory has one registered read port,
//  and the first character waits for a look-ahead fetch.
//  Reset clears counters, status and output registers and loads the default
//  terminator and backspace; the line memory and its read data are not
//  cleared. A stalled output holds the sequencer and the fetched byte.
// ----------------------------------------------------------------------------
module line_receive_buffer_with_backspace_unit
  import lrbb_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire        cfg_idx_i,
  input  wire [7:0]  cfg_data_i,
  lrbb_in_if.sink    in_i,
  lrbb_out_if.source out_o
);

  typedef enum logic [1:0] {
    SIdle,
    SFirst,
    SNext,
    SLast
  } state_e;

  state_e                state_q, state_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [AddrW-1:0]      len_q, len_d;
  status_e               status_q, status_d;
  logic [AddrW-1:0]      idx_q, idx_d;
  logic [7:0]            cur_q, cur_d;
  logic [7:0]            term_q, bksp_q;

  logic                  ov_q, ov_d;
  logic [1:0]            o_status_q, o_status_d;
  logic [7:0]            o_byte_q, o_byte_d;
  logic                  o_valid_q, o_valid_d;
  logic                  o_last_q, o_last_d;

  logic [7:0]            line_mem_q [LineSize];
  logic [7:0]            rd_data_q;
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [7:0]            mem_wdata;
  logic                  rd_en;
  logic [AddrW-1:0]      rd_addr;

  logic                  out_free;
  logic                  in_ready;
  logic [AddrW-1:0]      idx_nxt;
  logic [AddrW-1:0]      wr_pos;
  logic [AddrW-1:0]      bk_pos;

  assign out_free = !ov_q || out_o.ready;
  assign in_ready = (state_q == SIdle) && out_free;
  assign idx_nxt  = idx_q + AddrW'(1);
  assign wr_pos   = count_q[AddrW-1:0];
  assign bk_pos   = wr_pos - AddrW'(1);

  assign in_i.ready     = in_ready;
  assign out_o.valid    = ov_q;
  assign out_o.status   = o_status_q;
  assign out_o.out_byte = o_byte_q;
  assign out_o.out_valid = o_valid_q;
  assign out_o.last     = o_last_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    len_d      = len_q;
    status_d   = status_q;
    idx_d      = idx_q;
    cur_d      = cur_q;
    ov_d       = ov_q;
    o_status_d = o_status_q;
    o_byte_d   = o_byte_q;
    o_valid_d  = o_valid_q;
    o_last_d   = o_last_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;

    if (out_free) begin
      ov_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_i.valid && in_ready) begin
          if (op_e'(in_i.operation) == OpReceive) begin
            if (count_q == CountW'(LineSize)) begin
              // drop the byte, restart the line
              status_d = StOverflow;
              count_d  = '0;
            end else if (in_i.rx_byte == term_q) begin
              mem_we    = 1'b1;
              mem_waddr = wr_pos;
              len_d     = wr_pos;
              status_d  = StReady;
              count_d   = '0;
            end else if (in_i.rx_byte == bksp_q) begin
              if (count_q != '0) begin
                mem_we    = 1'b1;
                mem_waddr = bk_pos;
                count_d   = count_q - CountW'(1);
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = wr_pos;
              mem_wdata = in_i.rx_byte;
              count_d   = count_q + CountW'(1);
            end
            ov_d       = 1'b1;
            o_status_d = status_d;
            o_byte_d   = '0;
            o_valid_d  = 1'b0;
            o_last_d   = 1'b1;
          end else begin
            status_d = StEmpty;
            if (len_q == '0) begin
              ov_d       = 1'b1;
              o_status_d = StEmpty;
              o_byte_d   = '0;
              o_valid_d  = 1'b0;
              o_last_d   = 1'b1;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = SFirst;
            end
          end
        end
      end
      SFirst: begin
        if (out_free) begin
          if (rd_data_q == '0) begin
            ov_d       = 1'b1;
            o_status_d = StEmpty;
            o_byte_d   = '0;
            o_valid_d  = 1'b0;
            o_last_d   = 1'b1;
            state_d    = SIdle;
          end else if (len_q == AddrW'(1)) begin
            ov_d       = 1'b1;
            o_status_d = StEmpty;
            o_byte_d   = rd_data_q;
            o_valid_d  = 1'b1;
            o_last_d   = 1'b1;
            state_d    = SIdle;
          end else begin
            // fetch ahead so the last flag is known when a byte leaves
            cur_d   = rd_data_q;
            idx_d   = '0;
            rd_en   = 1'b1;
            rd_addr = AddrW'(1);
            state_d = SNext;
          end
        end
      end
      SNext: begin
        if (out_free) begin
          ov_d       = 1'b1;
          o_status_d = StEmpty;
          o_byte_d   = cur_q;
          o_valid_d  = 1'b1;
          o_last_d   = (rd_data_q == '0);
          if (rd_data_q == '0) begin
            state_d = SIdle;
          end else begin
            cur_d = rd_data_q;
            idx_d = idx_nxt;
            if (idx_nxt + AddrW'(1) == len_q) begin
              state_d = SLast;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx_nxt + AddrW'(1);
            end
          end
        end
      end
      SLast: begin
        if (out_free) begin
          ov_d       = 1'b1;
          o_status_d = StEmpty;
          o_byte_d   = cur_q;
          o_valid_d  = 1'b1;
          o_last_d   = 1'b1;
          state_d    = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      count_q    <= '0;
      len_q      <= '0;
      status_q   <= StEmpty;
      idx_q      <= '0;
      cur_q      <= '0;
      term_q     <= TermReset;
      bksp_q     <= BkspReset;
      ov_q       <= 1'b0;
      o_status_q <= '0;
      o_byte_q   <= '0;
      o_valid_q  <= 1'b0;
      o_last_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      len_q      <= len_d;
      status_q   <= status_d;
      idx_q      <= idx_d;
      cur_q      <= cur_d;
      ov_q       <= ov_d;
      o_status_q <= o_status_d;
      o_byte_q   <= o_byte_d;
      o_valid_q  <= o_valid_d;
      o_last_q   <= o_last_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgTerminator: term_q <= cfg_data_i;
          CfgBackspace:  bksp_q <= cfg_data_i;
          default:       term_q <= term_q;
        endcase
      end
    end
  end

  // line memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= line_mem_q[rd_addr];
    end
  end

endmodule : line_receive_buffer_with_backspace_unit
`default_nettype wire

/* bench/line_receive_buffer_with_backspace_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_receive_buffer_with_backspace_unit_tb - self-checking bench
// Drives receive and read beats through the valid/ready channels, predicts
// every output beat from a behavioral copy of the line buffer, and compares
// the results field by field. Runs several register settings and idling mixes.
// ----------------------------------------------------------------------------
module line_receive_buffer_with_backspace_unit_tb;
  import lrbb_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 300;
  localparam int SettleCycles  = 6;
  localparam int TailCycles    = 40;

  typedef struct packed {
    status_e    status;
    logic [7:0] data;
    logic       valid;
    logic       last;
  } line_beat_t;

  // Behavioral line buffer plus the queue of beats it predicts.
  class line_scoreboard;
    logic [7:0]  line_mem [LineSize];
    int unsigned fill_count;
    int unsigned line_len;
    status_e     state;
    logic [7:0]  term_char;
    logic [7:0]  bksp_char;
    line_beat_t  pending_beats [$];
    int          errors;

    function new();
      foreach (line_mem[i]) line_mem[i] = 8'h00;
      fill_count = 0;
      line_len   = 0;
      state      = StEmpty;
      term_char  = TermReset;
      bksp_char  = BkspReset;
      errors     = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [7:0] value);
      if (idx == CfgTerminator) term_char = value;
      else bksp_char = value;
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    function void note_input(op_e op, logic [7:0] rx);
      int unsigned limit;
      int unsigned n;
      if (op == OpReceive) begin
        if (fill_count >= LineSize) begin
          state      = StOverflow;
          fill_count = 0;
        end else if (rx == term_char) begin
          line_mem[fill_count] = 8'h00;
          line_len   = fill_count;
          state      = StReady;
          fill_count = 0;
        end else if (rx == bksp_char) begin
          if (fill_count != 0) begin
            fill_count--;
            line_mem[fill_count] = 8'h00;
          end
        end else begin
          line_mem[fill_count] = rx;
          fill_count++;
        end
        pending_beats.push_back('{state, 8'h00, 1'b0, 1'b1});
      end else begin
        state = StEmpty;
        limit = (line_len > LineSize - 1) ? LineSize - 1 : line_len;
        n = 0;
        while (n < limit && line_mem[n] != 8'h00) n++;
        if (n == 0) begin
          pending_beats.push_back('{StEmpty, 8'h00, 1'b0, 1'b1});
        end else begin
          for (int unsigned i = 0; i < n; i++)
            pending_beats.push_back('{StEmpty, line_mem[i], 1'b1, (i + 1 == n)});
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [7:0] data, logic valid, logic last);
      line_beat_t exp;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status=%0d byte=%02h valid=%0b last=%0b",
                                  st, data, valid, last));
      end else begin
        exp = pending_beats.pop_front();
        if (st !== exp.status)
          report_mismatch($sformatf("status %0d, want %0d", st, exp.status));
        if (data !== exp.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", data, exp.data));
        if (valid !== exp.valid)
          report_mismatch($sformatf("out_valid %0b, want %0b", valid, exp.valid));
        if (last !== exp.last)
          report_mismatch($sformatf("last %0b, want %0b", last, exp.last));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  lrbb_in_if  in_ch ();
  lrbb_out_if out_ch ();

  line_scoreboard store;
  int  items_sent;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  holdoff_req;

  line_receive_buffer_with_backspace_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        out_ch.ready = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        holdoff_req = 1'b0;
      end
      out_ch.ready = (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      store.check_result(out_ch.status, out_ch.out_byte, out_ch.out_valid, out_ch.last);
  end

  // Watchdog: end the run when no beat moves for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[%0t] watchdog expired", $time);
    $display("DONE: errors detected");
    $finish;
  end

  task send_item(op_e op, logic [7:0] rx);
    @(negedge clk_i);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.rx_byte   = rx;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    store.note_input(op, rx);
    items_sent++;
  endtask

  task go_quiet();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task wait_drained();
    while (store.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task write_register(cfg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    store.set_register(idx, value);
  endtask

  task reconfigure(logic [7:0] term, logic [7:0] bksp);
    go_quiet();
    wait_drained();
    write_register(CfgTerminator, term);
    write_register(CfgBackspace, bksp);
  endtask

  // Ordinary character: neither terminator nor backspace, zero now and then.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 24) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    end while (b == store.term_char || b == store.bksp_char);
    return b;
  endfunction

  task send_line(int len, bit with_read, int bksp_pct);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < bksp_pct) send_item(OpReceive, store.bksp_char);
      else send_item(OpReceive, plain_byte());
    end
    send_item(OpReceive, store.term_char);
    if (with_read) send_item(OpRead, 8'($urandom_range(0, 255)));
  endtask

  task send_overflow();
    repeat (LineSize) send_item(OpReceive, plain_byte());
    send_item(OpReceive, 8'($urandom_range(0, 255)));
  endtask

  task run_random(int upto);
    int sel;
    while (items_sent < upto) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        send_line(($urandom_range(0, 4) == 0) ? $urandom_range(11, LineSize - 1)
                                              : $urandom_range(0, 10),
                  $urandom_range(0, 99) < 85, 12);
      end else if (sel < 71) begin
        send_overflow();
        if ($urandom_range(0, 1)) send_item(OpRead, 8'($urandom_range(0, 255)));
      end else if (sel < 88) begin
        repeat ($urandom_range(1, 6))
          send_item(op_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (sel < 94) begin
        send_item(OpRead, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) send_item(OpReceive, store.bksp_char);
      end
    end
  endtask

  initial begin
    store           = new();
    items_sent      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    holdoff_req     = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgTerminator;
    cfg_data_i      = 8'h00;
    in_ch.valid     = 1'b0;
    in_ch.operation = OpReceive;
    in_ch.rx_byte   = 8'h00;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty reads, backspace at column zero, stored zero byte,
    // byte extremes, edits inside a line, repeated read of a closed line.
    send_item(OpRead, 8'hFF);
    send_item(OpReceive, BkspReset);
    send_item(OpReceive, 8'h00);
    send_item(OpReceive, TermReset);
    send_item(OpRead, 8'h00);
    send_item(OpReceive, 8'hFF);
    send_item(OpReceive, 8'h01);
    send_item(OpReceive, 8'h7F);
    send_item(OpReceive, BkspReset);
    send_item(OpReceive, 8'h80);
    send_item(OpReceive, TermReset);
    send_item(OpRead, 8'h55);
    send_item(OpRead, 8'hAA);
    send_item(OpReceive, 8'h61);
    send_item(OpReceive, BkspReset);
    send_item(OpReceive, BkspReset);
    send_item(OpReceive, TermReset);
    send_item(OpRead, 8'h00);
    send_item(OpReceive, 8'h55);
    send_item(OpReceive, 8'hAA);
    send_item(OpReceive, TermReset);
    send_item(OpRead, 8'h00);

    // Longest line; a full line overflows and overwrites it; then a read.
    send_line(LineSize - 1, 1'b1, 0);
    send_overflow();
    send_item(OpRead, 8'h00);
    run_random(130);

    // Register extremes, sender idling.
    reconfigure(8'h00, 8'hFF);
    send_idle_pct = 56;
    run_random(185);

    // Swapped extremes, receiver stalling; long hold-off fills the block first.
    reconfigure(8'hFF, 8'h00);
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    @(posedge clk_i);
    holdoff_req = 1'b1;
    send_line(LineSize - 1, 1'b1, 0);
    send_line(20, 1'b1, 0);
    send_item(OpRead, 8'h00);
    go_quiet();
    wait_drained();
    run_random(250);

    // Terminator and backspace share one value: terminator wins.
    reconfigure(8'h41, 8'h41);
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    send_line(5, 1'b1, 30);
    run_random(305);

    reconfigure(8'h0A, 8'h7F);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(350);

    go_quiet();
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (store.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : line_receive_buffer_with_backspace_unit_tb
